// ===== hw/rtl/i2c_eeprom_transaction_sequencer_unit_assert.svh =====
// Assertion macros used by the sequencer output queue.
`ifndef I2C_EEPROM_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_EEPROM_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define I2CSEQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define I2CSEQ_ASSERT_NEVER(lbl, cond, msg) \
	`I2CSEQ_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/i2cseq_pkg.sv =====
package i2cseq_pkg;

	// Page size of the EEPROM write buffer, in bytes
	localparam int PAGE_SIZE = 8;
	// Most result words one input word can cause
	localparam int MAX_RES = 4;
	localparam int CHUNK_W = $clog2(PAGE_SIZE + 1);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	// Register reset values
	localparam logic [7:0] DEV_ADDR_RESET = 8'd160;
	localparam logic [7:0] WAIT_MS_RESET = 8'd5;

	// Register indexes
	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_WRITE_WAIT_MS = 1'b1;

	// Device address read/write select
	localparam logic [7:0] DEV_WRITE_MASK = 8'hfe;
	localparam logic [7:0] DEV_READ_BIT = 8'h01;

	// Input operations
	localparam logic [2:0] OP_READ = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_WDATA = 3'd2;
	localparam logic [2:0] OP_ACK = 3'd3;
	localparam logic [2:0] OP_RBYTE = 3'd4;

	// Completion status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_W_DEV = 3'd1;
	localparam logic [2:0] ST_W_ADDR = 3'd2;
	localparam logic [2:0] ST_W_DATA = 3'd3;
	localparam logic [2:0] ST_R_DEV = 3'd4;
	localparam logic [2:0] ST_R_ADDR = 3'd5;
	localparam logic [2:0] ST_R_RDEV = 3'd6;

	typedef enum logic [3:0] {
		CMD_START = 4'd0,
		CMD_STOP = 4'd1,
		CMD_SEND = 4'd2,
		CMD_RECV = 4'd3,
		CMD_ACK = 4'd4,
		CMD_NACK = 4'd5,
		CMD_WAIT = 4'd6,
		CMD_NEED = 4'd7,
		CMD_DATA = 4'd8,
		CMD_DONE = 4'd9
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_R_DEV = 4'd1,
		PH_R_ADDR = 4'd2,
		PH_R_RDEV = 4'd3,
		PH_R_RECV = 4'd4,
		PH_W_DEV = 4'd5,
		PH_W_ADDR = 4'd6,
		PH_W_NEED = 4'd7,
		PH_W_DATA = 4'd8
	} phase_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] mem_addr;
		logic [8:0] byte_count;
		logic [7:0] write_data;
		logic       ack_bit;
		logic [7:0] received_byte;
	} item_t;

	typedef struct packed {
		cmd_t       bus_cmd;
		logic [7:0] bus_byte;
		logic [2:0] status;
	} result_t;

	// Group of results handed from the sequencer to the output queue
	typedef struct packed {
		logic                            valid;
		logic [RES_CNT_W-1:0]            count;
		result_t [MAX_RES-1:0]           res;
	} load_t;

	function automatic result_t mk_res(input cmd_t cmd, input logic [7:0] data,
		input logic [2:0] st);
		result_t r;
		r.bus_cmd = cmd;
		r.bus_byte = data;
		r.status = st;
		return r;
	endfunction

	// Bytes of the next write chunk: up to the page end, at most what is left
	function automatic logic [CHUNK_W-1:0] chunk_room(input logic [7:0] addr,
		input logic [8:0] rem);
		logic [8:0] room;
		room = 9'(PAGE_SIZE) - 9'(addr % PAGE_SIZE);
		if (rem <= room)
			return CHUNK_W'(rem);
		return CHUNK_W'(room);
	endfunction

endpackage

// ===== hw/rtl/i2cseq_ctrl.sv =====
module i2cseq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  i2cseq_pkg::item_t   in_item,
	input  logic [7:0]          dev_addr,
	input  logic [7:0]          wait_ms,
	input  logic                load_ok,
	output i2cseq_pkg::load_t   load
);
	import i2cseq_pkg::*;

	logic                 valid_s1;
	item_t                item_s1;
	logic                 fire;

	phase_t               phase_q, phase_d;
	logic [7:0]           addr_q, addr_d;
	logic [8:0]           rem_q, rem_d;
	logic [CHUNK_W-1:0]   chunk_q, chunk_d;

	logic [7:0]           addr_inc;
	logic [8:0]           rem_dec;
	logic [CHUNK_W-1:0]   chunk_dec;
	logic [7:0]           ec_addr;
	logic [8:0]           ec_rem;
	logic [CHUNK_W-1:0]   ec_room;
	logic [7:0]           dev_w, dev_r;
	logic                 is_ack, is_nack;

	result_t [MAX_RES-1:0] res;
	logic [RES_CNT_W-1:0]  n;

	// Input register: take a word when empty or when the held word moves on
	assign fire = valid_s1 && load_ok;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Shared arithmetic
	assign addr_inc = addr_q + 8'd1;
	assign rem_dec = rem_q - 9'd1;
	assign chunk_dec = chunk_q - CHUNK_W'(1);
	assign dev_w = dev_addr & DEV_WRITE_MASK;
	assign dev_r = dev_addr | DEV_READ_BIT;
	assign is_ack = (item_s1.op == OP_ACK) && !item_s1.ack_bit;
	assign is_nack = (item_s1.op == OP_ACK) && item_s1.ack_bit;

	// End of a write chunk sees the counters after the last data byte
	assign ec_addr = (phase_q == PH_W_DATA) ? addr_inc : addr_q;
	assign ec_rem = (phase_q == PH_W_DATA) ? rem_dec : rem_q;
	assign ec_room = chunk_room(ec_addr, ec_rem);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (item_s1.op == OP_READ)
					phase_d = PH_R_DEV;
				else if (item_s1.op == OP_WRITE)
					phase_d = PH_W_DEV;
			end
			PH_R_DEV: begin
				if (is_nack)
					phase_d = PH_IDLE;
				else if (is_ack)
					phase_d = PH_R_ADDR;
			end
			PH_R_ADDR: begin
				if (is_nack)
					phase_d = PH_IDLE;
				else if (is_ack)
					phase_d = PH_R_RDEV;
			end
			PH_R_RDEV: begin
				if (is_nack || (is_ack && rem_q == 9'd0))
					phase_d = PH_IDLE;
				else if (is_ack)
					phase_d = PH_R_RECV;
			end
			PH_R_RECV: begin
				if (item_s1.op == OP_RBYTE && rem_dec == 9'd0)
					phase_d = PH_IDLE;
			end
			PH_W_DEV: begin
				if (is_nack)
					phase_d = PH_IDLE;
				else if (is_ack)
					phase_d = PH_W_ADDR;
			end
			PH_W_ADDR: begin
				if (is_nack)
					phase_d = PH_IDLE;
				else if (is_ack && chunk_q != '0)
					phase_d = PH_W_NEED;
				else if (is_ack)
					phase_d = (ec_rem == 9'd0) ? PH_IDLE : PH_W_DEV;
			end
			PH_W_NEED: begin
				if (item_s1.op == OP_WDATA)
					phase_d = PH_W_DATA;
			end
			PH_W_DATA: begin
				if (is_nack)
					phase_d = PH_IDLE;
				else if (is_ack && chunk_dec != '0)
					phase_d = PH_W_NEED;
				else if (is_ack)
					phase_d = (ec_rem == 9'd0) ? PH_IDLE : PH_W_DEV;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Results and counter updates
	always_comb begin
		res = '0;
		n = '0;
		addr_d = addr_q;
		rem_d = rem_q;
		chunk_d = chunk_q;
		unique case (phase_q) inside
			PH_IDLE: begin
				if (item_s1.op == OP_READ || item_s1.op == OP_WRITE) begin
					addr_d = item_s1.mem_addr;
					rem_d = item_s1.byte_count;
					res[0] = mk_res(CMD_START, 8'd0, ST_OK);
					res[1] = mk_res(CMD_SEND, dev_w, ST_OK);
					n = RES_CNT_W'(2);
					if (item_s1.op == OP_WRITE)
						chunk_d = chunk_room(item_s1.mem_addr, item_s1.byte_count);
				end
			end
			PH_R_DEV, PH_W_DEV: begin
				if (is_nack) begin
					res[0] = mk_res(CMD_STOP, 8'd0, ST_OK);
					res[1] = mk_res(CMD_DONE, 8'd0,
						(phase_q == PH_R_DEV) ? ST_R_DEV : ST_W_DEV);
					n = RES_CNT_W'(2);
				end else if (is_ack) begin
					res[0] = mk_res(CMD_SEND, addr_q, ST_OK);
					n = RES_CNT_W'(1);
				end
			end
			PH_R_ADDR: begin
				if (is_nack) begin
					res[0] = mk_res(CMD_STOP, 8'd0, ST_OK);
					res[1] = mk_res(CMD_DONE, 8'd0, ST_R_ADDR);
					n = RES_CNT_W'(2);
				end else if (is_ack) begin
					res[0] = mk_res(CMD_START, 8'd0, ST_OK);
					res[1] = mk_res(CMD_SEND, dev_r, ST_OK);
					n = RES_CNT_W'(2);
				end
			end
			PH_R_RDEV: begin
				if (is_nack || (is_ack && rem_q == 9'd0)) begin
					res[0] = mk_res(CMD_STOP, 8'd0, ST_OK);
					res[1] = mk_res(CMD_DONE, 8'd0, is_nack ? ST_R_RDEV : ST_OK);
					n = RES_CNT_W'(2);
				end else if (is_ack) begin
					res[0] = mk_res(CMD_RECV, 8'd0, ST_OK);
					n = RES_CNT_W'(1);
				end
			end
			PH_R_RECV: begin
				if (item_s1.op == OP_RBYTE) begin
					addr_d = addr_inc;
					rem_d = rem_dec;
					res[0] = mk_res(CMD_DATA, item_s1.received_byte, ST_OK);
					if (rem_dec == 9'd0) begin
						res[1] = mk_res(CMD_NACK, 8'd0, ST_OK);
						res[2] = mk_res(CMD_STOP, 8'd0, ST_OK);
						res[3] = mk_res(CMD_DONE, 8'd0, ST_OK);
						n = RES_CNT_W'(4);
					end else begin
						res[1] = mk_res(CMD_ACK, 8'd0, ST_OK);
						res[2] = mk_res(CMD_RECV, 8'd0, ST_OK);
						n = RES_CNT_W'(3);
					end
				end
			end
			PH_W_ADDR, PH_W_DATA: begin
				if (is_nack) begin
					res[0] = mk_res(CMD_STOP, 8'd0, ST_OK);
					res[1] = mk_res(CMD_DONE, 8'd0,
						(phase_q == PH_W_ADDR) ? ST_W_ADDR : ST_W_DATA);
					n = RES_CNT_W'(2);
				end else if (is_ack) begin
					if (phase_q == PH_W_DATA) begin
						chunk_d = chunk_dec;
						rem_d = rem_dec;
						addr_d = addr_inc;
					end
					if ((phase_q == PH_W_ADDR) ? (chunk_q != '0) : (chunk_dec != '0)) begin
						res[0] = mk_res(CMD_NEED, 8'd0, ST_OK);
						n = RES_CNT_W'(1);
					end else begin
						// Close the page; start the next one if bytes remain
						res[0] = mk_res(CMD_STOP, 8'd0, ST_OK);
						res[1] = mk_res(CMD_WAIT, wait_ms, ST_OK);
						if (ec_rem == 9'd0) begin
							res[2] = mk_res(CMD_DONE, 8'd0, ST_OK);
							n = RES_CNT_W'(3);
						end else begin
							res[2] = mk_res(CMD_START, 8'd0, ST_OK);
							res[3] = mk_res(CMD_SEND, dev_w, ST_OK);
							n = RES_CNT_W'(4);
							chunk_d = ec_room;
						end
					end
				end
			end
			PH_W_NEED: begin
				if (item_s1.op == OP_WDATA) begin
					res[0] = mk_res(CMD_SEND, item_s1.write_data, ST_OK);
					n = RES_CNT_W'(1);
				end
			end
			default: begin
				n = '0;
			end
		endcase
	end

	// Commit the step when its results can be queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q <= '0;
			rem_q <= '0;
			chunk_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			addr_q <= addr_d;
			rem_q <= rem_d;
			chunk_q <= chunk_d;
		end
	end

	assign load.valid = fire;
	assign load.count = n;
	assign load.res = res;

endmodule

// ===== hw/rtl/i2cseq_outq.sv =====
`include "i2c_eeprom_transaction_sequencer_unit_assert.svh"

module i2cseq_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  i2cseq_pkg::load_t   load,
	output logic                load_ok,
	output logic                out_valid,
	input  logic                out_ready,
	output i2cseq_pkg::result_t out_res,
	output logic                out_last
);
	import i2cseq_pkg::*;

	logic [RES_CNT_W-1:0]  count_q;
	result_t [MAX_RES-1:0] ent_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign out_res = ent_q[0];
	assign out_last = (count_q == RES_CNT_W'(1));
	assign pop = out_valid && out_ready;

	// New group may enter when empty or while the final word leaves
	assign load_ok = !out_valid || (pop && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load.valid) begin
			count_q <= load.count;
		end else if (pop) begin
			count_q <= count_q - RES_CNT_W'(1);
		end
	end

	// Shift the held words toward the head
	always_ff @(posedge clk) begin
		if (load.valid) begin
			ent_q <= load.res;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++)
				ent_q[i] <= ent_q[i + 1];
		end
	end

	`I2CSEQ_ASSERT(a_load_when_free, load.valid |-> load_ok, "group loaded over pending words")
	`I2CSEQ_ASSERT_NEVER(a_count_range, count_q > RES_CNT_W'(MAX_RES), "queue count overflow")
	`I2CSEQ_ASSERT_NEVER(a_load_range, load.valid && load.count > RES_CNT_W'(MAX_RES), "group too large")
	`I2CSEQ_ASSERT(a_drain_empty, (pop && out_last && !load.valid) |=> !out_valid, "queue not empty after last word")

endmodule

// ===== hw/rtl/i2c_eeprom_transaction_sequencer_unit.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser op; tdata mem_addr..received_byte
// m_*       out  m_tvalid/m_tready  tuser bus_cmd; tdata bus_byte,status; tlast
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// An input word is registered, then stepped through the sequencer combinationally
// into a four-word output queue; the input takes a new word every cycle unless it stalls.
// Results leave one per cycle while m_tready is high; a word causing k results holds
// the output until all k have left, and the next word's group may load as the last leaves.
// Reset puts the sequencer in idle with both registers at their defaults.
// The input stalls only while its register holds a word and the queue still
// has earlier results to send.
module i2c_eeprom_transaction_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // mem_addr, byte_count, write_data, ack_bit, received_byte
	input  logic [2:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // bus_byte, status
	output logic [3:0]  m_tuser,   // bus_cmd
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import i2cseq_pkg::*;

	logic [7:0] dev_addr_q;
	logic [7:0] wait_ms_q;
	item_t      item;
	load_t      load;
	logic       load_ok;
	result_t    out_res;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
			wait_ms_q <= WAIT_MS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS: dev_addr_q <= cfg_data;
				REG_WRITE_WAIT_MS: wait_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the input word
	always_comb begin
		item.op = s_tuser;
		item.mem_addr = s_tdata[7:0];
		item.byte_count = s_tdata[16:8];
		item.write_data = s_tdata[24:17];
		item.ack_bit = s_tdata[25];
		item.received_byte = s_tdata[33:26];
	end

	i2cseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (item),
		.dev_addr (dev_addr_q),
		.wait_ms  (wait_ms_q),
		.load_ok  (load_ok),
		.load     (load)
	);

	i2cseq_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_ok   (load_ok),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.out_last  (m_tlast)
	);

	// Pack the output word
	assign m_tuser = out_res.bus_cmd;
	assign m_tdata = {5'd0, out_res.status, out_res.bus_byte};

endmodule
